@@ hw/rtl/bnskt_pkg.sv @@
// ----------------------------------------------------------------------------
// bnskt_pkg - shared types and constants for the sorted key table
// Request and response payload structs, command and status codes, sizes.
// ----------------------------------------------------------------------------
package bnskt_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int KEY_BITS    = 64;
   localparam int PTR_BITS    = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [2:0] {
      CMD_LEAF_FIND   = 3'd0,
      CMD_LEAF_INSERT = 3'd1,
      CMD_LEAF_DELETE = 3'd2,
      CMD_INNER_FIND  = 3'd3,
      CMD_INNER_INSERT = 3'd4,
      CMD_INNER_DELETE = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_KIND  = 3'd1,
      ST_FULL      = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      REG_PAGE_IS_LEAF = 1'd0,
      REG_MAX_KEYS     = 1'd1
   } reg_type;

   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] search_key;
      logic [63:0] payload_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] payload_out;
      logic [7:0]  keys_held;
   } rsp_type;

endpackage

@@ hw/rtl/btree_node_sorted_key_table.sv @@
// ----------------------------------------------------------------------------
// btree_node_sorted_key_table - one B-tree page as a sorted key table
// Find, insert and delete on ascending keys with payloads, one request at a
// time, driven by a small sequencer over a key/payload memory with one read and one write port.
// ----------------------------------------------------------------------------
// The page keeps up to 128 keys in ascending unsigned order, each paired with
// a 64-bit value (leaf page) or a 32-bit child pointer (inner page). One
// request is taken at a time; req_ready is low until its response has been
// loaded into the response register. The key search walks the stored keys
// from the lowest up through one shared comparator, with a memory read and
// then a compare for each key looked at, stopping at a match or the first
// larger key. An insert then opens a slot by moving every larger entry up one
// place, and a delete closes the gap by moving every larger entry down; each
// move is a memory read and a memory write. Requests rejected by the page
// kind, full or empty checks skip the search and go straight to the response.
// The memory needs no clearing pass: only entries below the key count are
// ever read.
// ----------------------------------------------------------------------------
module btree_node_sorted_key_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bnskt_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bnskt_pkg::rsp_type  rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int IDX_W = bnskt_pkg::IDX_W;
   localparam int CNT_W = bnskt_pkg::CNT_W;
   localparam int KEY_BITS = bnskt_pkg::KEY_BITS;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_LOOK  = 7'b0000100,
      S_CMP   = 7'b0001000,
      S_MVRD  = 7'b0010000,
      S_MVWR  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   // configuration registers
   logic       page_is_leaf_ff;
   logic [7:0] max_keys_ff;

   // sequencer and request state
   state_type             state_ff, state_in;
   bnskt_pkg::op_type     op_ff, op_in;
   logic                  want_leaf_ff, want_leaf_in;
   logic                  bad_ff, bad_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [63:0]           pl_ff, pl_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [2:0]            status_ff, status_in;
   logic [63:0]           pout_ff, pout_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   bnskt_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   // key and payload memory, one read and one write port
   logic [KEY_BITS-1:0]   key_mem [bnskt_pkg::MAX_ENTRIES];
   logic [63:0]           pl_mem  [bnskt_pkg::MAX_ENTRIES];
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [63:0]           pl_rd_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  mem_we;
   logic [IDX_W-1:0]      wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [63:0]           wr_pl;

   logic                  req_fire;
   logic                  cfg_write;
   logic [31:0]           cap;
   logic                  full;
   logic                  key_eq;
   logic                  key_gt;
   logic                  rsp_free;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_is_leaf_ff <= 1'b1;
         max_keys_ff     <= 8'd128;
      end else if (cfg_write) begin
         case (bnskt_pkg::reg_type'(csr_paddr[2]))
            bnskt_pkg::REG_PAGE_IS_LEAF: page_is_leaf_ff <= csr_pwdata[0];
            bnskt_pkg::REG_MAX_KEYS:     max_keys_ff     <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (bnskt_pkg::reg_type'(csr_paddr[2]))
         bnskt_pkg::REG_PAGE_IS_LEAF: csr_prdata = {31'd0, page_is_leaf_ff};
         bnskt_pkg::REG_MAX_KEYS:     csr_prdata = {24'd0, max_keys_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_addr] <= wr_key;
         pl_mem[wr_addr]  <= wr_pl;
      end
      key_rd_ff <= key_mem[rd_addr];
      pl_rd_ff  <= pl_mem[rd_addr];
   end

   // ---------------------------------------------------------------- shared compare
   // capacity is the smaller of max_keys and the memory depth
   assign cap  = (32'(max_keys_ff) < 32'(bnskt_pkg::MAX_ENTRIES)) ?
                 32'(max_keys_ff) : 32'(bnskt_pkg::MAX_ENTRIES);
   assign full   = (32'(count_ff) >= cap);
   assign key_eq = (key_rd_ff == key_ff);
   assign key_gt = (key_rd_ff > key_ff);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      want_leaf_in = want_leaf_ff;
      bad_in       = bad_ff;
      key_in       = key_ff;
      pl_in        = pl_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      pout_in      = pout_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = idx_ff[IDX_W-1:0];
      mem_we       = 1'b0;
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_key       = key_rd_ff;
      wr_pl        = pl_rd_ff;

      // drop the response once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in       = req_data.search_key[KEY_BITS-1:0];
               pl_in        = req_data.payload_in;
               bad_in       = 1'b0;
               want_leaf_in = 1'b1;
               op_in        = bnskt_pkg::OP_FIND;
               case (req_data.cmd) inside
                  bnskt_pkg::CMD_LEAF_FIND:    op_in = bnskt_pkg::OP_FIND;
                  bnskt_pkg::CMD_LEAF_INSERT:  op_in = bnskt_pkg::OP_INSERT;
                  bnskt_pkg::CMD_LEAF_DELETE:  op_in = bnskt_pkg::OP_DELETE;
                  bnskt_pkg::CMD_INNER_FIND: begin
                     op_in = bnskt_pkg::OP_FIND;
                     want_leaf_in = 1'b0;
                  end
                  bnskt_pkg::CMD_INNER_INSERT: begin
                     op_in = bnskt_pkg::OP_INSERT;
                     want_leaf_in = 1'b0;
                  end
                  bnskt_pkg::CMD_INNER_DELETE: begin
                     op_in = bnskt_pkg::OP_DELETE;
                     want_leaf_in = 1'b0;
                  end
                  default: bad_in = 1'b1;
               endcase
               state_in = S_CHECK;
            end
         end

         // order of checks: page kind, then full or empty, then the search
         S_CHECK: begin
            status_in = bnskt_pkg::ST_OK;
            pout_in   = 64'd0;
            idx_in    = '0;
            state_in  = S_LOOK;
            if (bad_ff || (want_leaf_ff != page_is_leaf_ff)) begin
               status_in = bnskt_pkg::ST_BAD_KIND;
               state_in  = S_DONE;
            end else if ((op_ff == bnskt_pkg::OP_INSERT) && full) begin
               status_in = bnskt_pkg::ST_FULL;
               state_in  = S_DONE;
            end else if ((op_ff == bnskt_pkg::OP_DELETE) && (count_ff == '0)) begin
               status_in = bnskt_pkg::ST_EMPTY;
               state_in  = S_DONE;
            end
         end

         // issue the read of entry idx, or end the scan past the last key
         S_LOOK: begin
            if (idx_ff == count_ff) begin
               pos_in = idx_ff;
               case (op_ff)
                  bnskt_pkg::OP_INSERT: begin
                     idx_in   = count_ff;
                     state_in = S_MVRD;
                  end
                  default: begin
                     status_in = bnskt_pkg::ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               endcase
            end else begin
               state_in = S_CMP;
            end
         end

         S_CMP: begin
            if (key_eq) begin
               pos_in = idx_ff;
               case (op_ff)
                  bnskt_pkg::OP_FIND: begin
                     pout_in  = want_leaf_ff ? pl_rd_ff : {32'd0, pl_rd_ff[31:0]};
                     state_in = S_DONE;
                  end
                  bnskt_pkg::OP_INSERT: begin
                     status_in = bnskt_pkg::ST_DUPLICATE;
                     state_in  = S_DONE;
                  end
                  default: begin
                     state_in = S_MVRD;
                  end
               endcase
            end else if (key_gt) begin
               pos_in = idx_ff;
               case (op_ff)
                  bnskt_pkg::OP_INSERT: begin
                     idx_in   = count_ff;
                     state_in = S_MVRD;
                  end
                  default: begin
                     status_in = bnskt_pkg::ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               endcase
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_LOOK;
            end
         end

         // move step: insert shifts up from the top, delete shifts down
         S_MVRD: begin
            if (op_ff == bnskt_pkg::OP_INSERT) begin
               if (idx_ff == pos_ff) begin
                  mem_we   = 1'b1;
                  wr_key   = key_ff;
                  wr_pl    = want_leaf_ff ? pl_ff : {32'd0, pl_ff[31:0]};
                  count_in = count_ff + 1'b1;
                  state_in = S_DONE;
               end else begin
                  rd_addr  = IDX_W'(idx_ff - 1'b1);
                  state_in = S_MVWR;
               end
            end else begin
               if ((idx_ff + 1'b1) >= count_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_DONE;
               end else begin
                  rd_addr  = IDX_W'(idx_ff + 1'b1);
                  state_in = S_MVWR;
               end
            end
         end

         S_MVWR: begin
            mem_we   = 1'b1;
            idx_in   = (op_ff == bnskt_pkg::OP_INSERT) ? idx_ff - 1'b1 : idx_ff + 1'b1;
            state_in = S_MVRD;
         end

         // hold until the response register is free, then load it
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.payload_out = pout_ff;
               rsp_data_in.keys_held   = 8'(count_ff);
               state_in                = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      want_leaf_ff <= want_leaf_in;
      bad_ff       <= bad_in;
      key_ff       <= key_in;
      pl_ff        <= pl_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      status_ff    <= status_in;
      pout_ff      <= pout_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // ---------------------------------------------------------------- assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(bnskt_pkg::MAX_ENTRIES))
      else $error("key count beyond memory depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_pout_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != bnskt_pkg::ST_OK)) |->
      (rsp_data_ff.payload_out == 64'd0))
      else $error("nonzero payload on rejected request");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_MVRD) |=> (count_ff == $past(count_ff)))
      else $error("key count changed outside move sequence");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for btree_node_sorted_key_table
// Drives find, insert and delete requests with bursty gaps, stalls the
// response side on changing patterns, keeps a shadow page to predict every
// response and checks each one field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

   // Command codes the page has no meaning for; both answer bad kind.
   localparam logic [2:0] CMD_SPARE_LOW  = 3'd6;
   localparam logic [2:0] CMD_SPARE_HIGH = 3'd7;

   localparam int          KEY_POOL_SIZE    = 160;
   localparam int          RANDOM_REQUESTS  = 1550;
   localparam int          SETTLE_CYCLES    = 600;
   localparam int          MAX_REPORTS      = 10;
   localparam logic [63:0] KEY_TOP_BIT      = 64'h8000_0000_0000_0000;
   localparam logic [63:0] KEY_BELOW_TOP    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALL_ONES         = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC,
      READY_SPARSE
   } ready_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   bnskt_pkg::req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   bnskt_pkg::rsp_type rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow page: keys, payloads, count and the two registers.
   logic [63:0] page_keys     [bnskt_pkg::MAX_ENTRIES];
   logic [63:0] page_payloads [bnskt_pkg::MAX_ENTRIES];
   int          key_count;
   logic        page_leaf;
   logic [7:0]  page_max;

   bnskt_pkg::req_type pending_requests [$];
   bnskt_pkg::rsp_type expected_responses [$];
   logic [63:0] key_pool [KEY_POOL_SIZE];

   int          queued_total;
   int          accepted_total;
   int          error_count;
   logic        req_taken;

   // Sender burst / gap bookkeeping.
   int          burst_left;
   int          gap_left;

   // Receiver stall pattern.
   ready_mode_type ready_mode;
   int          ready_mode_left;
   int          ready_period;
   int          ready_tick;

   btree_node_sorted_key_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Count a failure; print only the first few so the log stays short.
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endtask

   // Apply one request to the shadow page and return the response it must give.
   // Order of checks: page kind, then full or empty, then duplicate or missing.
   function automatic bnskt_pkg::rsp_type page_apply(input bnskt_pkg::req_type r);
      bnskt_pkg::rsp_type o;
      logic [63:0] k;
      int          pos;
      int          cap;
      bit          hit;
      bit          done;
      bit          want_leaf;
      o = '0;
      k = r.search_key;
      want_leaf = (r.cmd <= bnskt_pkg::CMD_LEAF_DELETE);
      cap = (page_max < bnskt_pkg::MAX_ENTRIES) ? int'(page_max) : bnskt_pkg::MAX_ENTRIES;
      // Walk the sorted keys: stop on a match or the first larger key.
      hit = 0;
      done = 0;
      pos = key_count;
      for (int i = 0; i < key_count && !done; i++) begin
         if (page_keys[i] == k) begin
            hit = 1;
            done = 1;
            pos = i;
         end else if (page_keys[i] > k) begin
            done = 1;
            pos = i;
         end
      end
      if (r.cmd > bnskt_pkg::CMD_INNER_DELETE || want_leaf != page_leaf) begin
         o.status = bnskt_pkg::ST_BAD_KIND;
      end else begin
         case (r.cmd)
            bnskt_pkg::CMD_LEAF_FIND, bnskt_pkg::CMD_INNER_FIND: begin
               if (!hit) begin
                  o.status = bnskt_pkg::ST_NOT_FOUND;
               end else if (want_leaf) begin
                  o.payload_out = page_payloads[pos];
               end else begin
                  // Inner find returns only the child pointer, even when the
                  // entry was written while the page was a leaf.
                  o.payload_out = {32'd0, page_payloads[pos][31:0]};
               end
            end
            bnskt_pkg::CMD_LEAF_INSERT, bnskt_pkg::CMD_INNER_INSERT: begin
               if (key_count + 1 > cap) begin
                  o.status = bnskt_pkg::ST_FULL;
               end else if (hit) begin
                  o.status = bnskt_pkg::ST_DUPLICATE;
               end else begin
                  // Open a slot: move every larger entry up one place.
                  for (int i = key_count; i > pos; i--) begin
                     page_keys[i]     = page_keys[i - 1];
                     page_payloads[i] = page_payloads[i - 1];
                  end
                  page_keys[pos]     = k;
                  page_payloads[pos] = want_leaf ? r.payload_in
                                                 : {32'd0, r.payload_in[31:0]};
                  key_count++;
               end
            end
            default: begin
               if (key_count == 0) begin
                  o.status = bnskt_pkg::ST_EMPTY;
               end else if (!hit) begin
                  o.status = bnskt_pkg::ST_NOT_FOUND;
               end else begin
                  // Close the gap: move every larger entry down one place.
                  for (int i = pos; i + 1 < key_count; i++) begin
                     page_keys[i]     = page_keys[i + 1];
                     page_payloads[i] = page_payloads[i + 1];
                  end
                  key_count--;
               end
            end
         endcase
      end
      o.keys_held = 8'(key_count);
      return o;
   endfunction

   task automatic add_request(input logic [2:0] cmd, input logic [63:0] key,
                              input logic [63:0] payload);
      bnskt_pkg::req_type r;
      r.cmd        = cmd;
      r.search_key = key;
      r.payload_in = payload;
      pending_requests.push_back(r);
      queued_total++;
   endtask

   // Hold off until every queued request is taken and every response is back.
   // Sample on the falling edge so the monitor's updates have settled.
   task automatic wait_until_drained();
      @(negedge clock);
      while (accepted_total != queued_total || expected_responses.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // APB write (setup, access), then read back and compare. Call only when idle.
   task automatic write_register(input bnskt_pkg::reg_type which,
                                 input logic [31:0] value);
      logic [31:0] stored;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      // Register took the write at the last rising edge; go straight to a
      // read setup on the same address.
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (which == bnskt_pkg::REG_PAGE_IS_LEAF) begin
         page_leaf = value[0];
         stored    = {31'd0, value[0]};
      end else begin
         page_max = value[7:0];
         stored   = {24'd0, value[7:0]};
      end
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== stored) begin
         report_mismatch($sformatf("register %0d readback exp %h got %h",
                                   which, stored, csr_prdata));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Driver: advance to the next request only when the current one was taken
   // (or none is up). Work in bursts with random gaps; some bursts are long
   // with no gap so back-to-back requests get exercised too.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               if ($urandom_range(0, 9) == 0) begin
                  burst_left = $urandom_range(100, 300);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: switch at random between four stall patterns.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode      = ready_mode_type'($urandom_range(0, 3));
         ready_mode_left = $urandom_range(20, 300);
         ready_period    = $urandom_range(2, 8);
      end else begin
         ready_mode_left--;
      end
      ready_tick++;
      case (ready_mode)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_RANDOM:   rsp_ready <= ($urandom_range(0, 99) < 70);
         READY_PERIODIC: rsp_ready <= ((ready_tick % ready_period) == 0);
         default:        rsp_ready <= ($urandom_range(0, 99) < 20);
      endcase
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on every accepted request, check every accepted
   // response against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      bnskt_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= (req_valid && req_ready === 1'b1);
         if (req_valid && req_ready === 1'b1) begin
            expected_responses.push_back(page_apply(req_data));
            accepted_total++;
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch($sformatf("response with none pending: %h", rsp_data));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_data.status !== want.status
                   || rsp_data.payload_out !== want.payload_out
                   || rsp_data.keys_held !== want.keys_held) begin
                  report_mismatch($sformatf(
                     "status exp %0d got %0d, payload exp %h got %h, keys exp %0d got %0d",
                     want.status, rsp_data.status, want.payload_out,
                     rsp_data.payload_out, want.keys_held, rsp_data.keys_held));
               end
            end
         end
      end
   end

   // Guard against a hung block: worst case is a full page at every request.
   initial begin
      #(20_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus: directed corner cases, then random phases, each phase under
   // its own register settings and drained before the next write.
   // ------------------------------------------------------------------------
   initial begin
      int          random_sent;
      int          phase_len;
      int          span;
      int          w_insert;
      int          w_delete;
      int          w_find;
      int          roll;
      int          cap_pick;
      logic [2:0]  cmd;
      logic [63:0] key;
      logic        op_leaf;

      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_taken   = 1'b0;
      key_count   = 0;
      page_leaf   = 1'b1;
      page_max    = 8'd128;
      queued_total    = 0;
      accepted_total  = 0;
      error_count     = 0;
      burst_left      = 1;
      gap_left        = 0;
      ready_mode      = READY_ALWAYS;
      ready_mode_left = 0;
      ready_period    = 2;
      ready_tick      = 0;
      random_sent     = 0;

      // Keys: extremes around the sign bit first, then a mix of widths.
      for (int i = 0; i < KEY_POOL_SIZE; i++) begin
         case (i)
            0:       key_pool[i] = 64'd0;
            1:       key_pool[i] = ALL_ONES;
            2:       key_pool[i] = KEY_TOP_BIT;
            3:       key_pool[i] = KEY_BELOW_TOP;
            4:       key_pool[i] = 64'd1;
            5:       key_pool[i] = ALL_ONES - 64'd1;
            default: key_pool[i] = {$urandom, $urandom} >> $urandom_range(0, 63);
         endcase
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Leaf page at reset settings: empty-page answers, ordering across the
      // sign bit, duplicates, wrong kind and spare codes.
      add_request(bnskt_pkg::CMD_LEAF_FIND,    KEY_TOP_BIT, 64'd0);
      add_request(bnskt_pkg::CMD_LEAF_DELETE,  KEY_TOP_BIT, 64'd0);
      add_request(bnskt_pkg::CMD_LEAF_INSERT,  64'd0,       ALL_ONES);
      add_request(bnskt_pkg::CMD_LEAF_INSERT,  ALL_ONES,    64'd0);
      add_request(bnskt_pkg::CMD_LEAF_INSERT,  KEY_TOP_BIT, {$urandom, $urandom});
      add_request(bnskt_pkg::CMD_LEAF_INSERT,  KEY_BELOW_TOP, {$urandom, $urandom});
      add_request(bnskt_pkg::CMD_LEAF_INSERT,  64'd0,       {$urandom, $urandom});
      add_request(bnskt_pkg::CMD_LEAF_FIND,    64'd0,       {$urandom, $urandom});
      add_request(bnskt_pkg::CMD_LEAF_FIND,    ALL_ONES,    64'd0);
      add_request(bnskt_pkg::CMD_LEAF_FIND,    64'd5,       64'd0);
      add_request(bnskt_pkg::CMD_INNER_FIND,   64'd0,       64'd0);
      add_request(bnskt_pkg::CMD_INNER_INSERT, 64'd9,       {$urandom, $urandom});
      add_request(bnskt_pkg::CMD_INNER_DELETE, 64'd0,       64'd0);
      add_request(CMD_SPARE_LOW,               64'd0,       ALL_ONES);
      add_request(CMD_SPARE_HIGH,              ALL_ONES,    64'd0);
      add_request(bnskt_pkg::CMD_LEAF_DELETE,  KEY_BELOW_TOP, 64'd0);
      add_request(bnskt_pkg::CMD_LEAF_DELETE,  KEY_BELOW_TOP, 64'd0);
      wait_until_drained();

      // Flip to inner with keys held: finds return only the low 32 bits.
      write_register(bnskt_pkg::REG_PAGE_IS_LEAF, 32'd0);
      add_request(bnskt_pkg::CMD_INNER_FIND,   64'd0,       64'd0);
      add_request(bnskt_pkg::CMD_INNER_FIND,   KEY_TOP_BIT, 64'd0);
      add_request(bnskt_pkg::CMD_LEAF_FIND,    64'd0,       64'd0);
      add_request(bnskt_pkg::CMD_INNER_INSERT, 64'd42,      ALL_ONES);
      add_request(bnskt_pkg::CMD_INNER_FIND,   64'd42,      64'd0);
      wait_until_drained();

      // Capacity below the count: insert full, find and delete still work.
      write_register(bnskt_pkg::REG_MAX_KEYS, 32'd2);
      add_request(bnskt_pkg::CMD_INNER_INSERT, 64'd7,       {$urandom, $urandom});
      add_request(bnskt_pkg::CMD_INNER_DELETE, 64'd42,      64'd0);
      add_request(bnskt_pkg::CMD_INNER_FIND,   ALL_ONES,    64'd0);
      wait_until_drained();

      // Zero capacity, then empty the page out.
      write_register(bnskt_pkg::REG_MAX_KEYS, 32'd0);
      add_request(bnskt_pkg::CMD_INNER_INSERT, 64'd7,       64'd0);
      add_request(bnskt_pkg::CMD_INNER_DELETE, 64'd0,       64'd0);
      add_request(bnskt_pkg::CMD_INNER_DELETE, ALL_ONES,    64'd0);
      add_request(bnskt_pkg::CMD_INNER_DELETE, KEY_TOP_BIT, 64'd0);
      add_request(bnskt_pkg::CMD_INNER_DELETE, 64'd0,       64'd0);
      add_request(bnskt_pkg::CMD_INNER_FIND,   64'd0,       64'd0);
      wait_until_drained();

      // Random phases. Most use small capacities to keep requests short; a
      // few fill the page toward its full 128 entries.
      while (random_sent < RANDOM_REQUESTS) begin
         cap_pick = $urandom_range(0, 99);
         if (cap_pick < 4)       page_max = 8'd0;
         else if (cap_pick < 10) page_max = 8'd1;
         else if (cap_pick < 60) page_max = 8'($urandom_range(2, 12));
         else if (cap_pick < 78) page_max = 8'($urandom_range(13, 40));
         else if (cap_pick < 84) page_max = 8'($urandom_range(64, 127));
         else if (cap_pick < 93) page_max = 8'd128;
         else                    page_max = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd200;
         write_register(bnskt_pkg::REG_PAGE_IS_LEAF,
                        {16'($urandom_range(0, 65535)), 15'd0,
                         1'($urandom_range(0, 1))});
         write_register(bnskt_pkg::REG_MAX_KEYS, {24'($urandom), page_max});

         if (page_max >= 8'd128) begin
            phase_len = $urandom_range(200, 300);
            span      = KEY_POOL_SIZE;
            w_insert  = 70;
            w_delete  = 10;
            w_find    = 20;
         end else begin
            phase_len = $urandom_range(30, 110);
            span      = int'(page_max) + $urandom_range(2, 16);
            if (span > KEY_POOL_SIZE) span = KEY_POOL_SIZE;
            w_insert  = $urandom_range(20, 60);
            w_delete  = $urandom_range(10, 40);
            w_find    = $urandom_range(10, 40);
         end
         // Trim the last phase so the total lands on the request budget.
         if (phase_len > RANDOM_REQUESTS - random_sent) begin
            phase_len = RANDOM_REQUESTS - random_sent;
         end

         for (int n = 0; n < phase_len; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)      key = key_pool[$urandom_range(0, span - 1)];
            else if (roll < 90) key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            else                key = {$urandom, $urandom};

            // Mostly the page's own kind; some wrong kind and spare codes.
            roll = $urandom_range(0, 99);
            op_leaf = (roll < 88) ? page_leaf : ~page_leaf;
            roll = $urandom_range(0, w_insert + w_delete + w_find - 1);
            if (roll < w_insert) begin
               cmd = op_leaf ? bnskt_pkg::CMD_LEAF_INSERT : bnskt_pkg::CMD_INNER_INSERT;
            end else if (roll < w_insert + w_delete) begin
               cmd = op_leaf ? bnskt_pkg::CMD_LEAF_DELETE : bnskt_pkg::CMD_INNER_DELETE;
            end else begin
               cmd = op_leaf ? bnskt_pkg::CMD_LEAF_FIND : bnskt_pkg::CMD_INNER_FIND;
            end
            if ($urandom_range(0, 99) < 4) begin
               cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HIGH : CMD_SPARE_LOW;
            end
            add_request(cmd, key, {$urandom, $urandom});
            random_sent++;
         end
         // Pause the sender until every response of the phase is back.
         wait_until_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
